>>> hw/rtl/rau_pkg.sv
// shared constants, codes and widths for the rational arithmetic unit
`default_nettype none

package rau_pkg;

	// operand field width, magnitudes fit in W bits, products in W2 bits
	localparam int W     = 32;
	localparam int W2    = 2 * W;
	localparam int CNT_W = $clog2(W2);

	// external field widths
	localparam int FIELD_W = 32;
	localparam int DEN_W   = 31;

	// 2^(W-1) at product width, bound for the reduced result
	localparam logic [W2-1:0] LIM = W2'(1) << (W - 1);

	// commands
	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_SUB = 2'd1;
	localparam logic [1:0] CMD_MUL = 2'd2;
	localparam logic [1:0] CMD_DIV = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_DIV_ZERO = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef logic [W-1:0]  mag_t;
	typedef logic [W2-1:0] wide_t;

endpackage

`default_nettype wire

>>> hw/rtl/rau_div.sv
// bit-serial restoring divider giving quotient and remainder at double width
`default_nettype none

module rau_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire rau_pkg::wide_t dividend,
	input  wire rau_pkg::wide_t divisor,
	output logic                done,
	output rau_pkg::wide_t      quo,
	output rau_pkg::wide_t      rem
);

	logic                      busy_q;
	logic                      done_q;
	logic [rau_pkg::CNT_W-1:0] cnt_q;
	rau_pkg::wide_t            rem_q;
	rau_pkg::wide_t            quo_q;
	rau_pkg::wide_t            dvs_q;

	logic [rau_pkg::W2:0] rem_sh;
	logic [rau_pkg::W2:0] rem_sub;
	logic                 ge;

	// shift in the next dividend bit, then trial subtract
	assign rem_sh  = {rem_q, quo_q[rau_pkg::W2-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign ge      = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= rau_pkg::CNT_W'(rau_pkg::W2 - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rau_pkg::W2'(rem_sub) : rau_pkg::W2'(rem_sh);
			quo_q <= {quo_q[rau_pkg::W2-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

>>> hw/rtl/rational_arithmetic_unit.sv
// top level: signed fraction add, subtract, multiply, divide with gcd reduction
`default_nettype none

// Takes one request of two signed fractions and a command, and returns one
// result in lowest terms with a positive denominator and the sign on the
// numerator. A zero denominator on either side gives status 1, a divide by
// a zero fraction gives status 2, and a reduced result that does not fit the
// field width gives status 3; on any error both result fields are zero. One
// request is worked at a time: in_stall is high from acceptance until the
// result is handed to the output register, which can still hold the previous
// result while the next request is taken. All remainders of Euclid's loop
// and the two final quotients go through one bit-serial divider of 64-bit
// width. The three cross products share one multiplier, one product a cycle.
// Requests that fail the zero checks skip the multiplier and the divider.

module rational_arithmetic_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic signed [31:0] left_num,
	input  wire logic signed [31:0] left_den,
	input  wire logic signed [31:0] right_num,
	input  wire logic signed [31:0] right_den,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [31:0] result_num,
	output logic [30:0]      result_den,
	output logic [1:0]       status
);

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_SUM   = 4'd2;
	localparam logic [3:0] S_GCD   = 4'd3;
	localparam logic [3:0] S_GCD_W = 4'd4;
	localparam logic [3:0] S_QN    = 4'd5;
	localparam logic [3:0] S_QN_W  = 4'd6;
	localparam logic [3:0] S_QD    = 4'd7;
	localparam logic [3:0] S_QD_W  = 4'd8;
	localparam logic [3:0] S_CHK   = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0] state_q;
	logic [1:0] step_q;

	// operand magnitudes and folded signs
	logic [1:0]       cmd_q;
	rau_pkg::mag_t    ln_q, ld_q, rn_q, rd_q;
	logic             s1_q, s2_q;

	// cross products and working values
	rau_pkg::wide_t   p1_q, p2_q;
	rau_pkg::wide_t   num_q, den_q;
	rau_pkg::wide_t   a_q, b_q;
	logic             sign_q;

	// finished result waiting for the output register
	logic signed [31:0] res_num_q;
	logic [30:0]        res_den_q;
	logic [1:0]         res_st_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] result_num_q;
	logic [30:0]        result_den_q;
	logic [1:0]         status_q;

	// input split into sign and magnitude over the low W bits
	logic [rau_pkg::W-1:0] ln_raw, ld_raw, rn_raw, rd_raw;
	rau_pkg::mag_t         ln_mag, ld_mag, rn_mag, rd_mag;
	logic                  in_take;

	assign ln_raw = left_num[rau_pkg::W-1:0];
	assign ld_raw = left_den[rau_pkg::W-1:0];
	assign rn_raw = right_num[rau_pkg::W-1:0];
	assign rd_raw = right_den[rau_pkg::W-1:0];
	assign ln_mag = ln_raw[rau_pkg::W-1] ? (~ln_raw + 1'b1) : ln_raw;
	assign ld_mag = ld_raw[rau_pkg::W-1] ? (~ld_raw + 1'b1) : ld_raw;
	assign rn_mag = rn_raw[rau_pkg::W-1] ? (~rn_raw + 1'b1) : rn_raw;
	assign rd_mag = rd_raw[rau_pkg::W-1] ? (~rd_raw + 1'b1) : rd_raw;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;

	// shared multiplier, operands picked by the product step
	rau_pkg::mag_t  mul_a, mul_b;
	rau_pkg::wide_t prod;

	always_comb begin
		unique case (step_q)
			2'd0: begin
				mul_a = ln_q;
				mul_b = (cmd_q == rau_pkg::CMD_MUL) ? rn_q : rd_q;
			end
			2'd1: begin
				mul_a = rn_q;
				mul_b = ld_q;
			end
			default: begin
				mul_a = ld_q;
				mul_b = rd_q;
			end
		endcase
	end

	assign prod = rau_pkg::W2'(mul_a) * rau_pkg::W2'(mul_b);

	// signed-magnitude combine of the numerator products
	rau_pkg::wide_t num_nx;
	logic           sign_nx;
	logic           sb;

	always_comb begin
		sb = (cmd_q == rau_pkg::CMD_SUB) ? !s2_q : s2_q;
		if (cmd_q == rau_pkg::CMD_ADD || cmd_q == rau_pkg::CMD_SUB) begin
			if (s1_q == sb) begin
				num_nx  = p1_q + p2_q;
				sign_nx = s1_q;
			end else if (p1_q >= p2_q) begin
				num_nx  = p1_q - p2_q;
				sign_nx = s1_q;
			end else begin
				num_nx  = p2_q - p1_q;
				sign_nx = sb;
			end
		end else begin
			num_nx  = p1_q;
			sign_nx = s1_q != s2_q;
		end
	end

	// shared divider: euclid remainders, then num/g and den/g
	logic           div_start;
	rau_pkg::wide_t div_dividend;
	logic           div_done;
	rau_pkg::wide_t div_quo, div_rem;

	assign div_start = (state_q == S_GCD) || (state_q == S_QN) || (state_q == S_QD);

	always_comb begin
		unique case (state_q)
			S_GCD:   div_dividend = a_q;
			S_QN:    div_dividend = num_q;
			default: div_dividend = den_q;
		endcase
	end

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (b_q),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// range check on the reduced result and signed numerator
	logic                  ovf;
	logic [31:0]           num_mag32;

	assign ovf = (den_q > rau_pkg::LIM - 1'b1)
		|| (num_q > (sign_q ? rau_pkg::LIM : rau_pkg::LIM - 1'b1));
	assign num_mag32 = 32'(num_q[rau_pkg::W-1:0]);

	// output register is free when empty or being taken this cycle
	logic out_free;
	logic out_load;

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_DONE) && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						step_q <= '0;
						if (ld_mag == '0 || rd_mag == '0 ||
						    (command == rau_pkg::CMD_DIV && rn_mag == '0))
							state_q <= S_DONE;
						else
							state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd2)
						state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= (num_nx == '0) ? S_DONE : S_GCD;
				end
				S_GCD:   state_q <= S_GCD_W;
				S_GCD_W: begin
					if (div_done)
						state_q <= (div_rem == '0) ? S_QN : S_GCD;
				end
				S_QN:    state_q <= S_QN_W;
				S_QN_W:  if (div_done) state_q <= S_QD;
				S_QD:    state_q <= S_QD_W;
				S_QD_W:  if (div_done) state_q <= S_CHK;
				S_CHK:   state_q <= S_DONE;
				S_DONE:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_take) begin
					cmd_q <= command;
					ln_q  <= ln_mag;
					ld_q  <= ld_mag;
					rn_q  <= rn_mag;
					rd_q  <= rd_mag;
					// zero numerator folds to a positive sign
					s1_q  <= (ln_raw[rau_pkg::W-1] != ld_raw[rau_pkg::W-1]) && (ln_mag != '0);
					s2_q  <= (rn_raw[rau_pkg::W-1] != rd_raw[rau_pkg::W-1]) && (rn_mag != '0);
					res_num_q <= '0;
					res_den_q <= '0;
					if (ld_mag == '0 || rd_mag == '0)
						res_st_q <= rau_pkg::ST_ZERO_DEN;
					else
						res_st_q <= rau_pkg::ST_DIV_ZERO;
				end
			end
			S_MUL: begin
				unique case (step_q)
					2'd0:    p1_q <= prod;
					2'd1:    p2_q <= prod;
					default: den_q <= (cmd_q == rau_pkg::CMD_DIV) ? p2_q : prod;
				endcase
			end
			S_SUM: begin
				num_q  <= num_nx;
				sign_q <= sign_nx;
				a_q    <= num_nx;
				b_q    <= den_q;
				// zero numerator gives 0/1
				res_num_q <= '0;
				res_den_q <= 31'd1;
				res_st_q  <= rau_pkg::ST_OK;
			end
			S_GCD_W: begin
				// on a zero remainder b_q holds the gcd
				if (div_done && div_rem != '0) begin
					a_q <= b_q;
					b_q <= div_rem;
				end
			end
			S_QN_W: if (div_done) num_q <= div_quo;
			S_QD_W: if (div_done) den_q <= div_quo;
			S_CHK: begin
				if (ovf) begin
					res_num_q <= '0;
					res_den_q <= '0;
					res_st_q  <= rau_pkg::ST_OVERFLOW;
				end else begin
					res_num_q <= sign_q ? -num_mag32 : num_mag32;
					res_den_q <= 31'(den_q[rau_pkg::W-1:0]);
					res_st_q  <= rau_pkg::ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_num_q <= res_num_q;
			result_den_q <= res_den_q;
			status_q     <= res_st_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign result_num = result_num_q;
	assign result_den = result_den_q;
	assign status     = status_q;

endmodule

`default_nettype wire
